@@ hw/rtl/far_pkg.sv @@
// ----------------------------------------------------------------------------
// far_pkg
// Shared widths, operation codes and payload types of the fraction unit.
// ----------------------------------------------------------------------------
package far_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int MAG_WIDTH     = PROD_WIDTH + 1;
   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 31;
   localparam int CNT_WIDTH     = $clog2(MAG_WIDTH + 1);

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   typedef struct packed {
      logic [1:0]                      op;
      logic signed [OPERAND_WIDTH-1:0] num_a;
      logic signed [OPERAND_WIDTH-1:0] den_a;
      logic signed [OPERAND_WIDTH-1:0] num_b;
      logic signed [OPERAND_WIDTH-1:0] den_b;
   } req_type;

   typedef struct packed {
      logic signed [RES_NUM_WIDTH-1:0] res_num;
      logic [RES_DEN_WIDTH-1:0]        res_den;
      logic                            status;
   } rsp_type;

   // raw fraction handed from front to back
   typedef struct packed {
      logic                 neg;
      logic                 zero_den;
      logic [MAG_WIDTH-1:0] num_mag;
      logic [MAG_WIDTH-1:0] den_mag;
   } raw_type;

endpackage

@@ hw/rtl/far_stream_if.sv @@
// ----------------------------------------------------------------------------
// far_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface far_req_if (input logic clock);
   logic              valid;
   logic              ready;
   far_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface far_rsp_if (input logic clock);
   logic              valid;
   logic              ready;
   far_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/fraction_arith_reduce_unit.sv @@
// ----------------------------------------------------------------------------
// fraction_arith_reduce_unit
// Rational add/sub/mul/div with reduction to lowest terms.
// path: front registers s0 and s1, the two-entry queue, then the gcd and divide states
// the serial reduce engine takes a new word only when idle, after its last result is taken
// zero numerators and zero denominators skip the gcd and divide states
// reset: synchronous, active high, clears all valid and state registers
// ----------------------------------------------------------------------------
module fraction_arith_reduce_unit (
   input logic      clock,
   input logic      reset,
   far_req_if.sink   req,
   far_rsp_if.source rsp
);
   logic             f_valid, f_ready, q_valid, q_ready;
   far_pkg::raw_type f_data, q_data;

   // front: products and sign
   far_front u_front (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   // decoupling queue
   far_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   // back: gcd and reduce
   far_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

@@ hw/rtl/far_front.sv @@
// ----------------------------------------------------------------------------
// far_front
// Forms raw numerator/denominator magnitudes and sign, three products a cycle unless the output stalls.
// ----------------------------------------------------------------------------
module far_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  far_pkg::req_type      in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output far_pkg::raw_type      out_data
);
   localparam int W = far_pkg::OPERAND_WIDTH;
   localparam int P = far_pkg::PROD_WIDTH;
   localparam int M = far_pkg::MAG_WIDTH;

   // stage 0: operand word, stage 1: products
   logic             s0_valid_ff, s0_valid_in;
   far_pkg::req_type s0_ff;
   logic             s1_valid_ff, s1_valid_in;
   logic [1:0]       s1_op_ff;
   logic signed [P-1:0] p0_ff, p1_ff, p2_ff;

   logic s1_take, s0_take;
   assign s1_take  = s1_valid_ff && out_ready;
   assign s0_take  = s0_valid_ff && (!s1_valid_ff || s1_take);
   assign in_ready = !s0_valid_ff || s0_take;

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (s0_take) s0_valid_in = 1'b0;
      if (in_valid && in_ready) s0_valid_in = 1'b1;
      s1_valid_in = s1_valid_ff;
      if (s1_take) s1_valid_in = 1'b0;
      if (s0_take) s1_valid_in = 1'b1;
   end

   // product selection by operation
   logic signed [W-1:0] x0, y0, x1, y1, x2, y2;
   always_comb begin
      x0 = s0_ff.num_a; y0 = s0_ff.den_b;
      x1 = s0_ff.num_b; y1 = s0_ff.den_a;
      x2 = s0_ff.den_a; y2 = s0_ff.den_b;
      unique case (s0_ff.op)
         far_pkg::OP_ADD, far_pkg::OP_SUB: ;
         far_pkg::OP_MUL: begin
            y0 = s0_ff.num_b;
         end
         default: begin
            y2 = s0_ff.num_b;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
      end
      if (in_valid && in_ready) s0_ff <= in_data;
      if (s0_take) begin
         s1_op_ff <= s0_ff.op;
         p0_ff    <= P'(x0) * P'(y0);
         p1_ff    <= P'(x1) * P'(y1);
         p2_ff    <= P'(x2) * P'(y2);
      end
   end

   // sum and magnitudes
   logic signed [M-1:0] rn, rd, p1e;
   always_comb begin
      p1e = M'(p1_ff);
      if (s1_op_ff == far_pkg::OP_ADD)      rn = M'(p0_ff) + p1e;
      else if (s1_op_ff == far_pkg::OP_SUB) rn = M'(p0_ff) - p1e;
      else                                  rn = M'(p0_ff);
      rd = M'(p2_ff);
      out_data.num_mag  = rn[M-1] ? M'(-rn) : rn;
      out_data.den_mag  = rd[M-1] ? M'(-rd) : rd;
      out_data.neg      = rn[M-1] ^ rd[M-1];
      out_data.zero_den = (rd == '0);
   end
   assign out_valid = s1_valid_ff;
endmodule

@@ hw/rtl/far_queue.sv @@
// ----------------------------------------------------------------------------
// far_queue
// Two-entry queue decoupling the front from the reduce engine.
// ----------------------------------------------------------------------------
module far_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  far_pkg::raw_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output far_pkg::raw_type  out_data
);
   far_pkg::raw_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wp_ff] <= in_data;
   end
endmodule

@@ hw/rtl/far_back.sv @@
// ----------------------------------------------------------------------------
// far_back
// Binary gcd of the magnitudes, then two restoring divisions by the gcd.
// ----------------------------------------------------------------------------
module far_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  far_pkg::raw_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output far_pkg::rsp_type  out_data
);
   localparam int M = far_pkg::MAG_WIDTH;
   localparam int C = far_pkg::CNT_WIDTH;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GCD  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_OUT  = 3'd3;
   localparam logic [2:0] ST_PACK = 3'd4;

   logic [2:0]   state_ff;
   logic [M-1:0] n_ff, d_ff;        // original magnitudes
   logic [M-1:0] x_ff, y_ff;        // gcd working pair
   logic [C-1:0] sh_ff;             // common power of two
   logic [M-1:0] g_ff;
   logic [M-1:0] qn_ff, qd_ff, rn_ff, rd_ff;
   logic [C-1:0] cnt_ff;
   logic         neg_ff;
   far_pkg::rsp_type res_ff;

   assign in_ready  = (state_ff == ST_IDLE) && !(out_valid && !out_ready);
   assign out_valid = (state_ff == ST_OUT);
   assign out_data  = res_ff;

   // one binary gcd step and one restoring divide step
   logic [M-1:0] dx, dy, rnt, rdt;
   logic [M:0]   rns, rds;
   always_comb begin
      dx = (x_ff > y_ff) ? x_ff - y_ff : y_ff - x_ff;
      dy = (x_ff > y_ff) ? y_ff : x_ff;
      rnt = {rn_ff[M-2:0], qn_ff[M-1]};
      rdt = {rd_ff[M-2:0], qd_ff[M-1]};
      rns = {1'b0, rnt} - {1'b0, g_ff};
      rds = {1'b0, rdt} - {1'b0, g_ff};
   end

   // numerator quotient, negated when the result is negative
   logic [M-1:0] nq;
   assign nq = neg_ff ? M'(-qn_ff) : qn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (in_valid) begin
               n_ff   <= in_data.num_mag;
               d_ff   <= in_data.den_mag;
               x_ff   <= in_data.num_mag;
               y_ff   <= in_data.den_mag;
               sh_ff  <= '0;
               neg_ff <= in_data.neg;
               if (in_data.zero_den || in_data.num_mag == '0) begin
                  res_ff.res_num <= '0;
                  res_ff.res_den <= far_pkg::RES_DEN_WIDTH'(1);
                  res_ff.status  <= in_data.zero_den;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_GCD;
               end
            end
            ST_GCD: begin
               if (x_ff == y_ff) begin
                  g_ff   <= x_ff << sh_ff;
                  qn_ff  <= n_ff;
                  qd_ff  <= d_ff;
                  rn_ff  <= '0;
                  rd_ff  <= '0;
                  cnt_ff <= '0;
                  state_ff <= ST_DIV;
               end else if (!x_ff[0] && !y_ff[0]) begin
                  x_ff <= x_ff >> 1; y_ff <= y_ff >> 1; sh_ff <= sh_ff + 1'b1;
               end else if (!x_ff[0]) begin
                  x_ff <= x_ff >> 1;
               end else if (!y_ff[0]) begin
                  y_ff <= y_ff >> 1;
               end else begin
                  x_ff <= dx >> 1; y_ff <= dy;
               end
            end
            ST_DIV: begin
               qn_ff <= {qn_ff[M-2:0], !rns[M]};
               qd_ff <= {qd_ff[M-2:0], !rds[M]};
               rn_ff <= rns[M] ? rnt : rns[M-1:0];
               rd_ff <= rds[M] ? rdt : rds[M-1:0];
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == C'(M - 1)) state_ff <= ST_PACK;
            end
            ST_PACK: begin
               res_ff.res_num <= far_pkg::RES_NUM_WIDTH'(nq);
               res_ff.res_den <= far_pkg::RES_DEN_WIDTH'(qd_ff);
               res_ff.status  <= 1'b0;
               state_ff <= ST_OUT;
            end
            ST_OUT: if (out_ready) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

@@ tb/far_tb_scoreboard.sv @@
// ----------------------------------------------------------------------------
// far_tb_scoreboard
// Predicts the reduced fraction for each accepted request word and checks
// response words against the predictions in order.
// ----------------------------------------------------------------------------
class far_tb_scoreboard;

   far_pkg::rsp_type pending_q[$];
   int               mismatch_count;
   int               stray_count;

   function new();
      mismatch_count = 0;
      stray_count    = 0;
   endfunction

   // magnitude and sign of one operand field
   function automatic void split_operand(input logic signed [15:0] v,
                                         output bit neg, output longint unsigned mag);
      longint signed s;
      s   = v;
      neg = s < 0;
      mag = neg ? -s : s;
   endfunction

   function automatic longint unsigned euclid(input longint unsigned x,
                                             input longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // reduced fraction for one request word
   function automatic far_pkg::rsp_type reduce_fraction(input far_pkg::req_type r);
      far_pkg::rsp_type p;
      longint signed na, da, nb, db, rn, rd;
      longint unsigned nm, dm, g;
      bit neg;
      na = r.num_a;
      da = r.den_a;
      nb = r.num_b;
      db = r.den_b;
      case (r.op)
         far_pkg::OP_ADD: begin
            rn = na * db + nb * da;
            rd = da * db;
         end
         far_pkg::OP_SUB: begin
            rn = na * db - nb * da;
            rd = da * db;
         end
         far_pkg::OP_MUL: begin
            rn = na * nb;
            rd = da * db;
         end
         default: begin
            rn = na * db;
            rd = da * nb;
         end
      endcase
      p.res_num = '0;
      p.res_den = 31'd1;
      p.status  = 1'b0;
      if (rd == 0) begin
         p.status = 1'b1;
      end else if (rn != 0) begin
         neg = (rn < 0) != (rd < 0);
         nm  = (rn < 0) ? -rn : rn;
         dm  = (rd < 0) ? -rd : rd;
         g   = euclid(nm, dm);
         nm  = nm / g;
         dm  = dm / g;
         if (neg) nm = -nm;
         p.res_num = nm[32:0];
         p.res_den = dm[30:0];
      end
      return p;
   endfunction

   function void note_request(input far_pkg::req_type r);
      pending_q.push_back(reduce_fraction(r));
   endfunction

   function void check_response(input far_pkg::rsp_type got);
      far_pkg::rsp_type want;
      if (pending_q.size() == 0) begin
         stray_count++;
         if (mismatch_count + stray_count <= 10)
            $display("unexpected response num=%0d den=%0d status=%0d",
                     got.res_num, got.res_den, got.status);
         return;
      end
      want = pending_q.pop_front();
      if (got.res_num !== want.res_num || got.res_den !== want.res_den
          || got.status !== want.status) begin
         mismatch_count++;
         if (mismatch_count + stray_count <= 10)
            $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                     want.res_num, want.res_den, want.status,
                     got.res_num, got.res_den, got.status);
      end
   endfunction

endclass

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random fraction operations through the unit, with
// phases of sender gaps and receiver stalls, and checks every response word.
// ----------------------------------------------------------------------------
module tb_top;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   cycle_count = 0;
   bit   failed;

   far_req_if req_if (clock);
   far_rsp_if rsp_if (clock);

   far_tb_scoreboard fraction_sb;

   fraction_arith_reduce_unit i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if.sink),
      .rsp   (rsp_if.source)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 800000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // response side: random stalls, check accepted words
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            fraction_sb.check_response(rsp_if.data);
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // send one request word, with random gaps before it
   task automatic send_word(input far_pkg::req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= w;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      fraction_sb.note_request(w);
   endtask

   task automatic send_fields(input logic [1:0] op, input int na, input int da,
                              input int nb, input int db);
      far_pkg::req_type w;
      w.op    = op;
      w.num_a = na[15:0];
      w.den_a = da[15:0];
      w.num_b = nb[15:0];
      w.den_b = db[15:0];
      send_word(w);
   endtask

   // operand with a bias toward extremes and small values
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3, 4, 5: return 16'($signed($urandom_range(24)) - 12);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_random(input int count);
      far_pkg::req_type w;
      for (int i = 0; i < count; i++) begin
         w.op    = 2'($urandom_range(3));
         w.num_a = pick_operand();
         w.den_a = pick_operand();
         w.num_b = pick_operand();
         w.den_b = pick_operand();
         send_word(w);
      end
   endtask

   initial begin
      fraction_sb    = new();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every op, extremes, zero denominators and numerators
      send_fields(far_pkg::OP_ADD, 1, 2, 1, 3);
      send_fields(far_pkg::OP_SUB, 1, 2, 1, 2);
      send_fields(far_pkg::OP_MUL, -3, 4, 2, 9);
      send_fields(far_pkg::OP_DIV, 3, 4, -9, 8);
      send_fields(far_pkg::OP_ADD, 1, 0, 1, 3);
      send_fields(far_pkg::OP_MUL, 1, 3, 1, 0);
      send_fields(far_pkg::OP_DIV, 1, 0, 1, 3);
      send_fields(far_pkg::OP_DIV, 1, 3, 0, 3);
      send_fields(far_pkg::OP_DIV, 5, 3, 2, 0);
      send_fields(far_pkg::OP_MUL, 0, -7, 5, 3);
      send_fields(far_pkg::OP_ADD, -32768, -32768, -32768, -32768);
      send_fields(far_pkg::OP_SUB, -32768, 1, 32767, 1);
      send_fields(far_pkg::OP_ADD, -32768, 1, -32768, 1);
      send_fields(far_pkg::OP_MUL, -32768, 1, -32768, 1);
      send_fields(far_pkg::OP_DIV, -32768, 1, 1, -32768);
      send_fields(far_pkg::OP_MUL, 32767, -32768, 32767, -32768);
      send_fields(far_pkg::OP_SUB, 32767, 32767, 32767, 32767);
      send_fields(far_pkg::OP_ADD, 32767, -1, -32768, 1);
      send_fields(far_pkg::OP_DIV, 1, -32768, -32768, 1);
      send_fields(far_pkg::OP_MUL, -1, -1, -1, -1);
      send_fields(far_pkg::OP_ADD, 65535, 65535, 0, 1);

      // random phases with different idle and stall mixes
      send_random(350);
      send_idle_pct = 63;
      send_random(350);
      send_idle_pct  = 0;
      recv_stall_pct = 63;
      send_random(350);
      send_idle_pct  = 27;
      recv_stall_pct = 27;
      send_random(350);
      req_if.valid <= 1'b0;

      // drain
      while (fraction_sb.pending_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      failed = fraction_sb.mismatch_count != 0 || fraction_sb.stray_count != 0;
      if (!failed) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
